[src/pfa_pkg.sv]
package pfa_pkg;

    localparam int NUM_PARTITIONS_DEF = 8;
    localparam int SIZE_BITS_DEF      = 16;

    localparam int SLOT_W     = 3;
    localparam int AMOUNT_W   = 16;
    localparam int MODE_W     = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic en;
    } pick_ctrl_t;

endpackage

[src/pfa_ram.sv]
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/pfa_picker.sv]
module pfa_picker #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 3
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pfa_pkg::pick_ctrl_t         ctrl,
    input  logic [pfa_pkg::MODE_W-1:0]  mode,
    input  logic [SIZE_BITS-1:0]        req,
    input  logic [IDX_W-1:0]            idx,
    input  logic [SIZE_BITS-1:0]        size,
    output logic                        grant,
    output logic [IDX_W-1:0]            best_idx,
    output logic [SIZE_BITS-1:0]        best_size
);

    import pfa_pkg::*;

    logic                 found_reg;
    logic                 found_next;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [IDX_W-1:0]     best_idx_next;
    logic [SIZE_BITS-1:0] best_size_reg;
    logic [SIZE_BITS-1:0] best_size_next;
    logic                 fits;
    logic                 take;

    always_comb begin
        fits = (req <= size);
        case (mode)
            FIT_BEST:  take = fits && (!found_reg || (size < best_size_reg));
            FIT_WORST: take = !found_reg || (size > best_size_reg);
            default:   take = fits && !found_reg;
        endcase

        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        if (ctrl.clear) begin
            found_next = 1'b0;
        end else if (ctrl.en && take) begin
            found_next     = 1'b1;
            best_idx_next  = idx;
            best_size_next = size;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
    end

    assign grant     = found_reg && ((mode != FIT_WORST) || (req <= best_size_reg));
    assign best_idx  = best_idx_reg;
    assign best_size = best_size_reg;

endmodule

[src/partition_fit_allocator.sv]
// A request result is offered after the scan, which reads one table entry per cycle from
// the RAM, and the commit state. s_tready is high only in idle, so no new request or load
// is taken until a request has committed; loads are taken one per cycle while idle.
// Commit waits while an earlier result is still held in the output register.
// Reset: aresetn is synchronous, active low; it clears the per-entry valid bits so the
// whole table reads as zero, sets fit_mode to first fit and empties the output register.
module partition_fit_allocator #(
    parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF,
    parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: slot[2:0], amount[18:3], zero fill [23:19]
    input  logic [pfa_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: func
    input  logic                           s_tuser,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: chosen_slot[2:0], size_before[18:3], size_after[34:19], zero fill [39:35]
    output logic [pfa_pkg::M_TDATA_W-1:0]  m_tdata,
    // tuser: granted
    output logic                           m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pfa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [pfa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [pfa_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    import pfa_pkg::*;

    localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
    localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [MODE_W-1:0]     fit_mode_reg;
    logic [SIZE_BITS-1:0]  req_reg;
    logic [NUM_PARTITIONS-1:0] valid_reg;
    logic                  rd_valid_reg;

    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic                  granted_reg;
    logic [SLOT_W-1:0]     chosen_slot_reg;
    logic [AMOUNT_W-1:0]   size_before_reg;
    logic [AMOUNT_W-1:0]   size_after_reg;

    logic [SLOT_W-1:0]     in_slot;
    logic [AMOUNT_W-1:0]   in_amount;
    logic                  in_accept;
    logic                  load_we;
    logic                  commit;
    logic                  commit_we;
    logic                  out_free;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SIZE_BITS-1:0]  ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [SIZE_BITS-1:0]  ram_rdata;
    logic [SIZE_BITS-1:0]  entry_size;

    pick_ctrl_t            pick_ctrl;
    logic                  pick_grant;
    logic [IDX_W-1:0]      pick_idx;
    logic [SIZE_BITS-1:0]  pick_size;
    logic [SIZE_BITS-1:0]  pick_after;
    logic [CNT_W-1:0]      cnt_prev;
    logic                  cfg_we;

    assign in_slot   = s_tdata[SLOT_W-1:0];
    assign in_amount = s_tdata[SLOT_W +: AMOUNT_W];
    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign load_we   = in_accept && (s_tuser == FUNC_LOAD)
                       && (32'(in_slot) < 32'(NUM_PARTITIONS));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign commit    = (state_reg == ST_COMMIT) && out_free;
    assign commit_we = commit && pick_grant;
    assign cnt_prev  = cnt_reg - 1'b1;
    assign pick_after = pick_size - req_reg;

    // configuration port
    assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? '0 : {{(APB_DATA_W-MODE_W){1'b0}}, fit_mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_mode_reg <= FIT_FIRST;
        end else if (cfg_we) begin
            fit_mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        pick_ctrl     = '{clear: 1'b0, en: 1'b0};
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_tuser == FUNC_REQUEST)) begin
                    state_next      = ST_SCAN;
                    cnt_next        = '0;
                    pick_ctrl.clear = 1'b1;
                end
            end
            ST_SCAN: begin
                pick_ctrl.en = (cnt_reg != '0);
                if (cnt_reg == CNT_W'(NUM_PARTITIONS)) begin
                    state_next = ST_COMMIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_reg <= SIZE_BITS'(in_amount);
        end
        if (commit) begin
            granted_reg     <= pick_grant;
            chosen_slot_reg <= pick_grant ? SLOT_W'(pick_idx) : '0;
            size_before_reg <= pick_grant ? AMOUNT_W'(pick_size) : '0;
            size_after_reg  <= pick_grant ? AMOUNT_W'(pick_after) : '0;
        end
    end

    // table storage; entries never written since reset read as zero
    assign ram_we    = load_we || commit_we;
    assign ram_waddr = commit_we ? pick_idx : IDX_W'(in_slot);
    assign ram_wdata = commit_we ? pick_after : SIZE_BITS'(in_amount);
    assign ram_raddr = (cnt_reg < CNT_W'(NUM_PARTITIONS)) ? cnt_reg[IDX_W-1:0] : '0;
    assign entry_size = rd_valid_reg ? ram_rdata : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            valid_reg[ram_waddr] <= 1'b1;
        end
        rd_valid_reg <= valid_reg[ram_raddr];
    end

    pfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_PARTITIONS),
        .AW    (IDX_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pfa_picker #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_picker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (pick_ctrl),
        .mode      (fit_mode_reg),
        .req       (req_reg),
        .idx       (cnt_prev[IDX_W-1:0]),
        .size      (entry_size),
        .grant     (pick_grant),
        .best_idx  (pick_idx),
        .best_size (pick_size)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = granted_reg;
    assign m_tdata  = {{(M_TDATA_W-SLOT_W-2*AMOUNT_W){1'b0}},
                       size_after_reg, size_before_reg, chosen_slot_reg};

`ifndef NO_ASSERTIONS
    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("table written during scan");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(NUM_PARTITIONS))
        else $error("scan counter out of range");

    a_grant_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        commit_we |-> (pick_size >= req_reg))
        else $error("granted partition smaller than request");

    a_wait_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !pick_grant) |=> (m_tvalid && !m_tuser && (m_tdata == '0)))
        else $error("waiting result carries nonzero fields");

    a_commit_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> (state_reg == ST_IDLE) && m_tvalid)
        else $error("commit did not present a result");
`endif

endmodule
